### rtl/sgeos_pkg.sv
// ----------------------------------------------------------------------------
// sgeos_pkg
// Shared constants and types for the stiffened-gas equation-of-state pipeline:
// fixed-point widths, register defaults, register map and pipeline flags.
// ----------------------------------------------------------------------------
package sgeos_pkg;

  // operand and result widths
  localparam int WORD_W     = 32;
  localparam int ENERGY_W   = 48;
  localparam int QUO_W      = 48;
  localparam int ROOT_W     = 48;
  localparam int RHO_NUM_W  = 113;
  localparam int RHO_DEN_W  = 96;
  localparam int E1_NUM_W   = 77;
  localparam int E2_NUM_W   = 128;
  localparam int E2_DEN_W   = 81;
  localparam int UNIT_LAT   = QUO_W + 1;

  // fixed-point constants
  localparam logic [WORD_W-1:0]   ONE_Q29 = 32'h2000_0000;
  localparam logic [WORD_W-1:0]   MAX32   = 32'hFFFF_FFFF;
  localparam logic [ENERGY_W-1:0] MAX48   = 48'hFFFF_FFFF_FFFF;

  // register defaults
  localparam logic [WORD_W-1:0] GAMMA_GAS_RST    = 32'd751619277;
  localparam logic [WORD_W-1:0] GAMMA_LIQUID_RST = 32'd2362232013;
  localparam logic [WORD_W-1:0] CP_GAS_RST       = 32'd65863680;
  localparam logic [WORD_W-1:0] CP_LIQUID_RST    = 32'd274333696;
  localparam logic [WORD_W-1:0] P_INF_RST        = 32'd600000000;

  // register map
  typedef enum logic [2:0] {
    CFG_GAMMA_GAS    = 3'd0,
    CFG_GAMMA_LIQUID = 3'd1,
    CFG_CP_GAS       = 3'd2,
    CFG_CP_LIQUID    = 3'd3,
    CFG_P_INF_LIQUID = 3'd4
  } cfg_idx_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic degen_gas;
    logic degen_liquid;
    logic nz_total;
  } flags_t;

endpackage

### rtl/sgeos_div.sv
// ----------------------------------------------------------------------------
// sgeos_div
// Pipelined restoring divider: one quotient bit per stage, MSB first, with an
// overflow flag when the quotient does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module sgeos_div #(
  parameter int NUM_W = sgeos_pkg::RHO_NUM_W,
  parameter int DEN_W = sgeos_pkg::RHO_DEN_W,
  parameter int QUO_W = sgeos_pkg::QUO_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic [QUO_W-1:0] out_quo,
  output logic             out_ovf
);

  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W+1];
  logic [DEN_W-1:0] den_r [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic             ovf_r [QUO_W+1];

  // input stage, overflow when num >= den * 2^QUO_W
  always_ff @(posedge clk) begin
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    ovf_r[0] <= (CMP_W'(in_num) >= (CMP_W'(in_den) << QUO_W));
  end

  // one compare-subtract per stage
  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - k;
    logic [CMP_W:0]   diff;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    always_comb begin
      diff         = {1'b0, CMP_W'(rem_r[k-1])} - {1'b0, (CMP_W'(den_r[k-1]) << BIT)};
      quo_nxt      = quo_r[k-1];
      quo_nxt[BIT] = ~diff[CMP_W];
      rem_nxt      = diff[CMP_W] ? rem_r[k-1] : NUM_W'(diff[CMP_W-1:0]);
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_r[k-1];
      quo_r[k] <= quo_nxt;
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign out_quo = quo_r[QUO_W];
  assign out_ovf = ovf_r[QUO_W];

endmodule

### rtl/sgeos_sqrt.sv
// ----------------------------------------------------------------------------
// sgeos_sqrt
// Pipelined integer square root: one root bit per stage, MSB first, keeping
// the running remainder radicand - root^2.
// ----------------------------------------------------------------------------
module sgeos_sqrt #(
  parameter int ROOT_W = sgeos_pkg::ROOT_W
) (
  input  logic                clk,
  input  logic [2*ROOT_W-1:0] in_rad,
  output logic [ROOT_W-1:0]   out_root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CMP_W = RAD_W + 1;

  logic [RAD_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];

  // input stage
  always_ff @(posedge clk) begin
    rem_r[0]  <= in_rad;
    root_r[0] <= '0;
  end

  // try setting one root bit per stage
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
    localparam int BIT = ROOT_W - k;
    logic [CMP_W-1:0]  trial;
    logic [CMP_W:0]    diff;
    logic [RAD_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      trial         = (CMP_W'(root_r[k-1]) << (BIT + 1)) | (CMP_W'(1) << (2 * BIT));
      diff          = {1'b0, CMP_W'(rem_r[k-1])} - {1'b0, trial};
      root_nxt      = root_r[k-1];
      root_nxt[BIT] = ~diff[CMP_W];
      rem_nxt       = diff[CMP_W] ? rem_r[k-1] : RAD_W'(diff[CMP_W-1:0]);
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
    end
  end

  assign out_root = root_r[ROOT_W];

endmodule

### rtl/stiffened_gas_eos_evaluator.sv
// ----------------------------------------------------------------------------
// stiffened_gas_eos_evaluator
// Densities, internal energies and sound speeds of an ideal gas and a
// stiffened liquid from pressure and both phase temperatures, fully pipelined.
//
//   channel  ports                                   transaction when
//   input    start, busy, in_*                       start && !busy
//   result   out_valid, out_*                        out_valid (one cycle)
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One cell enters per clock; busy is always low and cfg_ready always high.
// A result reaches the result ports through the capture stage, three multiply
// stages, the 49-stage divider and square-root pipelines and the output stage.
// Synchronous active-low reset clears the valid bits and loads register
// defaults. The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module stiffened_gas_eos_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pressure,
  input  logic [31:0] in_temp_gas,
  input  logic [31:0] in_temp_liquid,
  output logic        out_valid,
  output logic [31:0] out_rho_gas,
  output logic [31:0] out_rho_liquid,
  output logic [47:0] out_energy_gas,
  output logic [47:0] out_energy_liquid,
  output logic [31:0] out_speed_gas,
  output logic [31:0] out_speed_liquid,
  output logic        out_invalid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int QW  = sgeos_pkg::QUO_W;
  localparam int LAT = sgeos_pkg::UNIT_LAT;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [31:0] gamma_gas_r, gamma_liquid_r, cp_gas_r, cp_liquid_r, p_inf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_gas_r    <= sgeos_pkg::GAMMA_GAS_RST;
      gamma_liquid_r <= sgeos_pkg::GAMMA_LIQUID_RST;
      cp_gas_r       <= sgeos_pkg::CP_GAS_RST;
      cp_liquid_r    <= sgeos_pkg::CP_LIQUID_RST;
      p_inf_r        <= sgeos_pkg::P_INF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sgeos_pkg::cfg_idx_t'(cfg_index))
        sgeos_pkg::CFG_GAMMA_GAS:    gamma_gas_r    <= cfg_data;
        sgeos_pkg::CFG_GAMMA_LIQUID: gamma_liquid_r <= cfg_data;
        sgeos_pkg::CFG_CP_GAS:       cp_gas_r       <= cfg_data;
        sgeos_pkg::CFG_CP_LIQUID:    cp_liquid_r    <= cfg_data;
        sgeos_pkg::CFG_P_INF_LIQUID: p_inf_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: capture transaction and total liquid pressure
  logic        v0_r;
  logic [31:0] p0_r, tg0_r, tl0_r;
  logic [32:0] tot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    p0_r   <= in_pressure;
    tg0_r  <= in_temp_gas;
    tl0_r  <= in_temp_liquid;
    tot0_r <= {1'b0, in_pressure} + {1'b0, p_inf_r};
  end

  // stage 1: first products and degenerate-phase checks
  logic [31:0] dg_gas, dg_liq;
  sgeos_pkg::flags_t fl1_nxt;

  always_comb begin
    dg_gas = gamma_gas_r - sgeos_pkg::ONE_Q29;
    dg_liq = gamma_liquid_r - sgeos_pkg::ONE_Q29;
    fl1_nxt.degen_gas    = (tg0_r == '0) || (cp_gas_r == '0) ||
                           (gamma_gas_r <= sgeos_pkg::ONE_Q29);
    fl1_nxt.degen_liquid = (tl0_r == '0) || (cp_liquid_r == '0) ||
                           (gamma_liquid_r <= sgeos_pkg::ONE_Q29);
    fl1_nxt.nz_total     = (tot0_r != '0);
  end

  logic              v1_r;
  sgeos_pkg::flags_t fl1_r;
  logic [31:0]       tg1_r, tl1_r;
  logic [63:0]       dcg1_r, dcl1_r, ctg1_r, ctl1_r, pd1_r;
  logic [64:0]       pgg1_r, pgl1_r, gt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    fl1_r  <= fl1_nxt;
    tg1_r  <= tg0_r;
    tl1_r  <= tl0_r;
    dcg1_r <= 64'(dg_gas) * 64'(cp_gas_r);
    dcl1_r <= 64'(dg_liq) * 64'(cp_liquid_r);
    ctg1_r <= 64'(cp_gas_r) * 64'(tg0_r);
    ctl1_r <= 64'(cp_liquid_r) * 64'(tl0_r);
    pd1_r  <= 64'(p_inf_r) * 64'(dg_liq);
    pgg1_r <= 65'(p0_r) * 65'(gamma_gas_r);
    pgl1_r <= 65'(tot0_r) * 65'(gamma_liquid_r);
    gt1_r  <= 65'(gamma_liquid_r) * 65'(tot0_r);
  end

  // stage 2: partial products of the wide multiplies
  logic              v2_r;
  sgeos_pkg::flags_t fl2_r;
  logic [63:0]       dg_lo2_r, dg_hi2_r, dl_lo2_r, dl_hi2_r;
  logic [63:0]       n00_2_r, n01_2_r, n10_2_r, n11_2_r;
  logic [63:0]       ctg2_r, ctl2_r;
  logic [64:0]       pgg2_r, pgl2_r, gt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    fl2_r    <= fl1_r;
    dg_lo2_r <= 64'(dcg1_r[31:0]) * 64'(tg1_r);
    dg_hi2_r <= 64'(dcg1_r[63:32]) * 64'(tg1_r);
    dl_lo2_r <= 64'(dcl1_r[31:0]) * 64'(tl1_r);
    dl_hi2_r <= 64'(dcl1_r[63:32]) * 64'(tl1_r);
    n00_2_r  <= 64'(pd1_r[31:0]) * 64'(ctl1_r[31:0]);
    n01_2_r  <= 64'(pd1_r[31:0]) * 64'(ctl1_r[63:32]);
    n10_2_r  <= 64'(pd1_r[63:32]) * 64'(ctl1_r[31:0]);
    n11_2_r  <= 64'(pd1_r[63:32]) * 64'(ctl1_r[63:32]);
    ctg2_r   <= ctg1_r;
    ctl2_r   <= ctl1_r;
    pgg2_r   <= pgg1_r;
    pgl2_r   <= pgl1_r;
    gt2_r    <= gt1_r;
  end

  // stage 3: sum partial products into K * 2^61 and the stiffening numerator
  logic              v3_r;
  sgeos_pkg::flags_t fl3_r;
  logic [95:0]       deng3_r, denl3_r;
  logic [127:0]      num3_r;
  logic [63:0]       ctg3_r, ctl3_r;
  logic [64:0]       pgg3_r, pgl3_r, gt3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    fl3_r   <= fl2_r;
    deng3_r <= 96'(dg_lo2_r) + {dg_hi2_r, 32'b0};
    denl3_r <= 96'(dl_lo2_r) + {dl_hi2_r, 32'b0};
    num3_r  <= 128'(n00_2_r) + 128'({n01_2_r, 32'b0}) + 128'({n10_2_r, 32'b0}) +
               {n11_2_r, 64'b0};
    ctg3_r  <= ctg2_r;
    ctl3_r  <= ctl2_r;
    pgg3_r  <= pgg2_r;
    pgl3_r  <= pgl2_r;
    gt3_r   <= gt2_r;
  end

  // valid and flags alongside the divider and root pipelines
  logic              v_dly_r  [LAT];
  sgeos_pkg::flags_t fl_dly_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_dly_r[i] <= 1'b0;
    end else begin
      v_dly_r[0] <= v3_r;
      for (int i = 1; i < LAT; i++) v_dly_r[i] <= v_dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    fl_dly_r[0] <= fl3_r;
    for (int i = 1; i < LAT; i++) fl_dly_r[i] <= fl_dly_r[i-1];
  end

  // divider and square-root units
  logic [QW-1:0] rho_g_q, rho_l_q, e1_g_q, e1_l_q, e2_q;
  logic          rho_g_ovf, rho_l_ovf, e1_g_ovf, e1_l_ovf, e2_ovf;
  logic [sgeos_pkg::ROOT_W-1:0] root_g, root_l;

  sgeos_div #(
    .NUM_W (sgeos_pkg::RHO_NUM_W), .DEN_W (sgeos_pkg::RHO_DEN_W), .QUO_W (QW)
  ) u_div_rho_gas (
    .clk (clk), .in_num ({pgg3_r, 48'b0}), .in_den (deng3_r),
    .out_quo (rho_g_q), .out_ovf (rho_g_ovf)
  );

  sgeos_div #(
    .NUM_W (sgeos_pkg::RHO_NUM_W), .DEN_W (sgeos_pkg::RHO_DEN_W), .QUO_W (QW)
  ) u_div_rho_liq (
    .clk (clk), .in_num ({pgl3_r, 48'b0}), .in_den (denl3_r),
    .out_quo (rho_l_q), .out_ovf (rho_l_ovf)
  );

  sgeos_div #(
    .NUM_W (sgeos_pkg::E1_NUM_W), .DEN_W (sgeos_pkg::WORD_W), .QUO_W (QW)
  ) u_div_e_gas (
    .clk (clk), .in_num ({ctg3_r, 13'b0}), .in_den (gamma_gas_r),
    .out_quo (e1_g_q), .out_ovf (e1_g_ovf)
  );

  sgeos_div #(
    .NUM_W (sgeos_pkg::E1_NUM_W), .DEN_W (sgeos_pkg::WORD_W), .QUO_W (QW)
  ) u_div_e_liq (
    .clk (clk), .in_num ({ctl3_r, 13'b0}), .in_den (gamma_liquid_r),
    .out_quo (e1_l_q), .out_ovf (e1_l_ovf)
  );

  sgeos_div #(
    .NUM_W (sgeos_pkg::E2_NUM_W), .DEN_W (sgeos_pkg::E2_DEN_W), .QUO_W (QW)
  ) u_div_e_stiff (
    .clk (clk), .in_num (num3_r), .in_den ({gt3_r, 16'b0}),
    .out_quo (e2_q), .out_ovf (e2_ovf)
  );

  sgeos_sqrt #(.ROOT_W (sgeos_pkg::ROOT_W)) u_sqrt_gas (
    .clk (clk), .in_rad (96'(deng3_r[95:29])), .out_root (root_g)
  );

  sgeos_sqrt #(.ROOT_W (sgeos_pkg::ROOT_W)) u_sqrt_liq (
    .clk (clk), .in_rad (96'(denl3_r[95:29])), .out_root (root_l)
  );

  // output stage: saturation, stiffening sum and invalid flag
  sgeos_pkg::flags_t fl_o;
  logic [31:0] rho_g_nxt, rho_l_nxt, spd_g_nxt, spd_l_nxt;
  logic [47:0] e_g_nxt, e_l_nxt, e2_val;
  logic [48:0] e_sum;
  logic        bad_nxt;

  always_comb begin
    fl_o    = fl_dly_r[LAT-1];
    bad_nxt = 1'b0;
    e2_val  = e2_ovf ? sgeos_pkg::MAX48 : e2_q;
    e_sum   = 49'(e1_l_ovf ? sgeos_pkg::MAX48 : e1_l_q) + 49'(e2_val);

    // gas phase
    if (fl_o.degen_gas) begin
      rho_g_nxt = sgeos_pkg::MAX32;
      e_g_nxt   = '0;
      spd_g_nxt = '0;
      bad_nxt   = 1'b1;
    end else begin
      rho_g_nxt = (rho_g_ovf || (rho_g_q[47:32] != '0)) ? sgeos_pkg::MAX32 : rho_g_q[31:0];
      e_g_nxt   = e1_g_ovf ? sgeos_pkg::MAX48 : e1_g_q;
      spd_g_nxt = (root_g[47:32] != '0) ? sgeos_pkg::MAX32 : root_g[31:0];
      bad_nxt   = rho_g_ovf || (rho_g_q[47:32] != '0) || e1_g_ovf ||
                  (root_g[47:32] != '0);
    end

    // liquid phase
    if (fl_o.degen_liquid) begin
      rho_l_nxt = sgeos_pkg::MAX32;
      e_l_nxt   = '0;
      spd_l_nxt = '0;
      bad_nxt   = 1'b1;
    end else begin
      rho_l_nxt = (rho_l_ovf || (rho_l_q[47:32] != '0)) ? sgeos_pkg::MAX32 : rho_l_q[31:0];
      spd_l_nxt = (root_l[47:32] != '0) ? sgeos_pkg::MAX32 : root_l[31:0];
      if (rho_l_ovf || (rho_l_q[47:32] != '0) || e1_l_ovf || (root_l[47:32] != '0)) begin
        bad_nxt = 1'b1;
      end
      e_l_nxt = e1_l_ovf ? sgeos_pkg::MAX48 : e1_l_q;
      // stiffening term p_inf / rho_liquid
      if (fl_o.nz_total) begin
        if (e2_ovf || e_sum[48]) bad_nxt = 1'b1;
        e_l_nxt = e_sum[48] ? sgeos_pkg::MAX48 : e_sum[47:0];
      end
    end
  end

  logic        out_valid_r;
  logic [31:0] rho_g_r, rho_l_r, spd_g_r, spd_l_r;
  logic [47:0] e_g_r, e_l_r;
  logic        bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v_dly_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    rho_g_r <= rho_g_nxt;
    rho_l_r <= rho_l_nxt;
    e_g_r   <= e_g_nxt;
    e_l_r   <= e_l_nxt;
    spd_g_r <= spd_g_nxt;
    spd_l_r <= spd_l_nxt;
    bad_r   <= bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rho_gas       = rho_g_r;
  assign out_rho_liquid    = rho_l_r;
  assign out_energy_gas    = e_g_r;
  assign out_energy_liquid = e_l_r;
  assign out_speed_gas     = spd_g_r;
  assign out_speed_liquid  = spd_l_r;
  assign out_invalid       = bad_r;

endmodule
